// ----- hdl/gpr_pkg.sv -----
`default_nettype none

package gpr_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned POS_W  = 10;
    localparam int unsigned CODE_W = 3;

    localparam logic [POS_W-1:0]  SIZE_POS    = 10'd10;
    localparam logic [POS_W-1:0]  TABLE_START = 10'd13;
    localparam logic [POS_W-1:0]  POS_MAX     = 10'd1023;
    localparam logic [BYTE_W-1:0] LEVEL_MAX   = 8'hff;

    // Bytes per table size step: three bytes per entry, two entries at code zero.
    localparam logic [POS_W-1:0]  TABLE_UNIT  = 10'd6;

    typedef enum logic [1:0] {
        CH_RED   = 2'd0,
        CH_GREEN = 2'd1,
        CH_BLUE  = 2'd2
    } t_chan;

    typedef enum logic [2:0] {
        REG_FORE_RED   = 3'd0,
        REG_FORE_GREEN = 3'd1,
        REG_FORE_BLUE  = 3'd2,
        REG_BACK_RED   = 3'd3,
        REG_BACK_GREEN = 3'd4,
        REG_BACK_BLUE  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [BYTE_W-1:0] fore_red;
        logic [BYTE_W-1:0] fore_green;
        logic [BYTE_W-1:0] fore_blue;
        logic [BYTE_W-1:0] back_red;
        logic [BYTE_W-1:0] back_green;
        logic [BYTE_W-1:0] back_blue;
    } t_colors;

    // One parsed byte handed from the tracker to the blend stage.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              recolor;
        t_chan             chan;
        logic [BYTE_W-1:0] white;
    } t_stage;

endpackage

`default_nettype wire

// ----- hdl/gpr_tracker.sv -----
`default_nettype none

module gpr_tracker
    import gpr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    input  wire logic [BYTE_W-1:0] i_s_tdata,
    input  wire logic              i_s_tlast,
    input  wire logic              i_adv,
    output logic                   o_s_tready,
    output logic                   o_valid,
    output t_stage                 o_stage
);

    logic [POS_W-1:0]  r_pos,   n_pos;
    logic [CODE_W-1:0] r_code,  n_code;
    t_chan             r_chan,  n_chan;
    logic [BYTE_W-1:0] r_white, n_white;
    logic              r_valid;
    t_stage            r_stage;

    logic              accept;
    logic              is_size;
    logic              in_table;
    logic [POS_W-1:0]  table_end;
    t_chan             chan;
    t_chan             chan_next;
    logic [BYTE_W-1:0] white;

    assign o_s_tready = !r_valid || i_adv;
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        is_size   = (r_pos == SIZE_POS);
        table_end = TABLE_START + (TABLE_UNIT << r_code);
        in_table  = !is_size && (r_pos >= TABLE_START) && (r_pos < table_end);
        chan      = (r_pos == TABLE_START) ? CH_RED : r_chan;
        white     = (chan == CH_RED) ? i_s_tdata : r_white;
        case (chan)
            CH_RED:   chan_next = CH_GREEN;
            CH_GREEN: chan_next = CH_BLUE;
            CH_BLUE:  chan_next = CH_RED;
            default:  chan_next = CH_RED;
        endcase
    end

    always_comb begin
        n_pos   = r_pos;
        n_code  = r_code;
        n_chan  = r_chan;
        n_white = r_white;
        if (is_size) begin
            n_code = i_s_tdata[CODE_W-1:0];
        end
        if (in_table) begin
            n_chan  = chan_next;
            n_white = white;
        end
        if (i_s_tlast) begin
            n_pos   = '0;
            n_chan  = CH_RED;
            n_white = '0;
        end else if (r_pos < POS_MAX) begin
            n_pos = r_pos + 10'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_code  <= '0;
            r_chan  <= CH_RED;
            r_white <= '0;
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_pos   <= n_pos;
                r_code  <= n_code;
                r_chan  <= n_chan;
                r_white <= n_white;
            end
            if (o_s_tready) begin
                r_valid <= i_s_tvalid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_stage.data    <= i_s_tdata;
            r_stage.last    <= i_s_tlast;
            r_stage.recolor <= in_table;
            r_stage.chan    <= chan;
            r_stage.white   <= white;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

`ifndef SYNTHESIS
    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_s_tlast |=> r_pos == '0 && r_chan == CH_RED && r_white == '0)
        else $error("position not restarted after last byte");

    a_pos_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !i_s_tlast && r_pos != POS_MAX |=> r_pos == $past(r_pos) + 10'd1)
        else $error("byte position did not advance");

    a_code_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && r_pos == SIZE_POS |=> r_code == $past(i_s_tdata[CODE_W-1:0]))
        else $error("table size code not latched");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_adv |=> r_valid && $stable(r_pos))
        else $error("stage lost or state moved while stalled");
`endif

endmodule

`default_nettype wire

// ----- hdl/gpr_blend.sv -----
`default_nettype none

module gpr_blend
    import gpr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire t_stage            i_stage,
    input  wire t_colors           i_colors,
    input  wire logic              i_m_tready,
    output logic                   o_adv,
    output logic                   o_m_tvalid,
    output logic [BYTE_W-1:0]      o_m_tdata,
    output logic                   o_m_tlast
);

    // x / 255 for x up to 255 * 255: add the high byte back in, then shift.
    function automatic logic [BYTE_W-1:0] div255(input logic [2*BYTE_W-1:0] x);
        logic [2*BYTE_W:0] t;
        t = {1'b0, x} + 17'd1 + {9'd0, x[2*BYTE_W-1:BYTE_W]};
        return t[2*BYTE_W-1:BYTE_W];
    endfunction

    logic [BYTE_W-1:0]   fg;
    logic [BYTE_W-1:0]   bg;
    logic [BYTE_W-1:0]   w_inv;
    logic [2*BYTE_W-1:0] mix;
    logic [BYTE_W-1:0]   result;

    logic              r_valid;
    logic [BYTE_W-1:0] r_data;
    logic              r_last;

    always_comb begin
        case (i_stage.chan)
            CH_RED: begin
                fg = i_colors.fore_red;
                bg = i_colors.back_red;
            end
            CH_GREEN: begin
                fg = i_colors.fore_green;
                bg = i_colors.back_green;
            end
            CH_BLUE: begin
                fg = i_colors.fore_blue;
                bg = i_colors.back_blue;
            end
            default: begin
                fg = i_colors.fore_red;
                bg = i_colors.back_red;
            end
        endcase
        w_inv  = LEVEL_MAX - i_stage.white;
        mix    = ({8'd0, i_stage.white} * {8'd0, fg}) + ({8'd0, w_inv} * {8'd0, bg});
        result = i_stage.recolor ? div255(mix) : i_stage.data;
    end

    assign o_adv = !r_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && i_valid) begin
            r_data <= result;
            r_last <= i_stage.last;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_data;
    assign o_m_tlast  = r_last;

endmodule

`default_nettype wire

// ----- hdl/gif_palette_recolor.sv -----
// Each byte is registered in the tracker, then in the blend output register.
// Throughput: one byte per cycle while the master side is ready; the tracker and
//   the output register each hold one byte, and ready follows back through both stages.
// Reset (synchronous, active low): position, size code, channel and whiteness
//   clear, both stages empty, colors return to white foreground, black background.
`default_nettype none

module gif_palette_recolor
    import gpr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // Slave side. tdata: [7:0] in_byte. tlast: in_last.
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [BYTE_W-1:0] i_s_tdata,
    input  wire logic              i_s_tlast,
    // Master side. tdata: [7:0] out_byte. tlast: out_last.
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic [BYTE_W-1:0]      o_m_tdata,
    output logic                   o_m_tlast,
    // Color register writes; indexes past the blue background are dropped.
    input  wire logic              i_cfg_we,
    input  wire logic [2:0]        i_cfg_idx,
    input  wire logic [BYTE_W-1:0] i_cfg_data
);

    t_colors r_colors;
    t_stage  stage;
    logic    stage_valid;
    logic    blend_adv;

    // Hold the six color levels; write one per enabled cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_colors.fore_red   <= LEVEL_MAX;
            r_colors.fore_green <= LEVEL_MAX;
            r_colors.fore_blue  <= LEVEL_MAX;
            r_colors.back_red   <= '0;
            r_colors.back_green <= '0;
            r_colors.back_blue  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FORE_RED:   r_colors.fore_red   <= i_cfg_data;
                REG_FORE_GREEN: r_colors.fore_green <= i_cfg_data;
                REG_FORE_BLUE:  r_colors.fore_blue  <= i_cfg_data;
                REG_BACK_RED:   r_colors.back_red   <= i_cfg_data;
                REG_BACK_GREEN: r_colors.back_green <= i_cfg_data;
                REG_BACK_BLUE:  r_colors.back_blue  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage one: track the byte position and decide which bytes are palette bytes.
    gpr_tracker u_tracker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_adv      (blend_adv),
        .o_s_tready (o_s_tready),
        .o_valid    (stage_valid),
        .o_stage    (stage)
    );

    // Stage two: blend palette bytes between background and foreground, register result.
    gpr_blend u_blend (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (stage_valid),
        .i_stage    (stage),
        .i_colors   (r_colors),
        .i_m_tready (i_m_tready),
        .o_adv      (blend_adv),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

`default_nettype wire
